// ===== hw/rtl/dht_pkg.sv =====
// Shared types, constants and codes of the double-hashing table.
`default_nettype none

package dht_pkg;

  // Storage geometry
  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int SIZE_W      = $clog2(TABLE_DEPTH + 1);

  // Field and register widths
  localparam int VALUE_W     = 31;
  localparam int SIZE_CFG_W  = 9;
  localparam int PRIME_W     = 8;
  localparam int SLOT_W      = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 9;
  localparam int BIT_CNT_W   = $clog2(VALUE_W);

  // Register reset values
  localparam logic [SIZE_CFG_W-1:0] SIZE_RESET  = SIZE_CFG_W'(256);
  localparam logic [PRIME_W-1:0]    PRIME_RESET = PRIME_W'(251);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TABLE_SIZE   = 1'b0,
    REG_SECOND_PRIME = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    STATUS_INSERTED  = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_FOUND     = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    opcode_t              opcode;
    logic [VALUE_W-1:0]   value;
  } in_item_t;

  typedef struct packed {
    status_t              status;
    logic [SLOT_W-1:0]    slot;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_SETUP,
    ST_STEP,
    ST_PSETUP,
    ST_PROBE,
    ST_PUSH
  } ctrl_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic clr_write;
    logic load;
    logic div_run;
    logic step_load;
    logic probe_load;
    logic probe_run;
    logic res_load;
    logic out_load;
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clr_last;
    logic div_last;
    logic probe_hit;
    logic probe_last;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dht_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none

module dht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dht_ctrl.sv =====
// Controller state machine of the double-hashing table.
`default_nettype none

module dht_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output logic                     item_ready,
  output logic                     result_valid,
  input  wire logic                result_ready,
  input  wire dht_pkg::dp_status_t sts,
  output dht_pkg::ctrl_cmd_t       cmd
);
  import dht_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        result_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;

    unique case (state)
      ST_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_HASH;
        end
      end
      ST_HASH: begin
        cmd.div_run = 1'b1;
        if (sts.div_last) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.step_load = 1'b1;
        state_next    = ST_STEP;
      end
      ST_STEP: begin
        cmd.div_run = 1'b1;
        if (sts.div_last) begin
          state_next = ST_PSETUP;
        end
      end
      ST_PSETUP: begin
        cmd.probe_load = 1'b1;
        state_next     = ST_PROBE;
      end
      ST_PROBE: begin
        cmd.probe_run = 1'b1;
        if (sts.probe_hit || sts.probe_last) begin
          cmd.res_load = 1'b1;
          state_next   = ST_PUSH;
        end
      end
      ST_PUSH: begin
        // hold until the output register is free
        if (!result_valid || result_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      result_valid_next = 1'b1;
    end else if (result_ready) begin
      result_valid_next = 1'b0;
    end else begin
      result_valid_next = result_valid;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dht_datapath.sv =====
// Datapath: config registers, remainder units, probe sequencing and slot store.
`default_nettype none

module dht_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [dht_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [dht_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire dht_pkg::in_item_t                   item,
  output dht_pkg::out_item_t                       result,
  input  wire dht_pkg::ctrl_cmd_t                  cmd,
  output dht_pkg::dp_status_t                      sts
);
  import dht_pkg::*;

  // Configuration
  logic [SIZE_CFG_W-1:0] table_size;
  logic [PRIME_W-1:0]    second_prime;
  logic [SIZE_W-1:0]     n_eff;
  logic [PRIME_W-1:0]    p_eff;
  logic [ADDR_W:0]       n_x;

  // Item and remainder units
  opcode_t               op;
  logic [VALUE_W-1:0]    val;
  logic [VALUE_W-1:0]    dq;
  logic [ADDR_W-1:0]     r1;
  logic [PRIME_W-1:0]    r2;
  logic [BIT_CNT_W-1:0]  bit_cnt;
  logic [ADDR_W:0]       t1;
  logic [PRIME_W:0]      t2;
  logic [ADDR_W-1:0]     r1_next;
  logic [PRIME_W-1:0]    r2_next;
  logic [PRIME_W-1:0]    step_diff;

  // Probe sequencing
  logic [ADDR_W-1:0]     pos;
  logic [ADDR_W-1:0]     prev_pos;
  logic [ADDR_W-1:0]     step_r;
  logic [SIZE_W-1:0]     cnt;
  logic                  cmp_valid;
  logic [ADDR_W:0]       sum;
  logic [ADDR_W-1:0]     pos_adv;
  logic                  match;

  // Store and clearing sweep
  logic [ADDR_W-1:0]     clr_addr;
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [VALUE_W-1:0]    ram_wdata;
  logic [VALUE_W-1:0]    ram_rdata;

  out_item_t             res;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size   <= SIZE_RESET;
      second_prime <= PRIME_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_TABLE_SIZE) begin
        table_size <= cfg_data[SIZE_CFG_W-1:0];
      end else begin
        second_prime <= cfg_data[PRIME_W-1:0];
      end
    end
  end

  // Clamp table size into 1 .. TABLE_DEPTH, prime zero acts as one
  always_comb begin
    if (table_size == '0) begin
      n_eff = SIZE_W'(1);
    end else if (32'(table_size) > 32'(TABLE_DEPTH)) begin
      n_eff = SIZE_W'(TABLE_DEPTH);
    end else begin
      n_eff = SIZE_W'(table_size);
    end
    p_eff = (second_prime == '0) ? PRIME_W'(1) : second_prime;
    n_x   = (ADDR_W + 1)'(n_eff);
  end

  // One restoring-remainder bit per cycle for both units
  always_comb begin
    t1        = {r1, dq[VALUE_W-1]};
    t2        = {r2, dq[VALUE_W-1]};
    r1_next   = (t1 >= n_x) ? ADDR_W'(t1 - n_x) : ADDR_W'(t1);
    r2_next   = (t2 >= {1'b0, p_eff}) ? PRIME_W'(t2 - {1'b0, p_eff}) : PRIME_W'(t2);
    step_diff = p_eff - r2;
  end

  always_comb begin
    sum     = (ADDR_W + 1)'(pos) + (ADDR_W + 1)'(step_r);
    pos_adv = (sum >= n_x) ? ADDR_W'(sum - n_x) : ADDR_W'(sum);
    match   = (op == OP_INSERT) ? (ram_rdata == '0) : (ram_rdata == val);
    sts.probe_hit  = cmp_valid && match;
    sts.probe_last = cmp_valid && (cnt == n_eff - SIZE_W'(1));
    sts.div_last   = (bit_cnt == BIT_CNT_W'(VALUE_W - 1));
    sts.clr_last   = (clr_addr == ADDR_W'(TABLE_DEPTH - 1));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op      <= item.opcode;
      val     <= item.value;
      dq      <= item.value;
      r1      <= '0;
      r2      <= '0;
      bit_cnt <= '0;
    end else if (cmd.step_load) begin
      // keep the home slot, start the step reduction on the top bits
      pos     <= r1;
      r1      <= '0;
      dq      <= {step_diff, (VALUE_W - PRIME_W)'(0)};
      bit_cnt <= BIT_CNT_W'(VALUE_W - PRIME_W);
    end else if (cmd.div_run) begin
      r1      <= r1_next;
      r2      <= r2_next;
      dq      <= {dq[VALUE_W-2:0], 1'b0};
      bit_cnt <= bit_cnt + BIT_CNT_W'(1);
    end

    if (cmd.probe_load) begin
      step_r    <= r1;
      cnt       <= '0;
      cmp_valid <= 1'b0;
    end else if (cmd.probe_run) begin
      pos       <= pos_adv;
      prev_pos  <= pos;
      cmp_valid <= 1'b1;
      if (cmp_valid) begin
        cnt <= cnt + SIZE_W'(1);
      end
    end

    if (cmd.res_load) begin
      if (op == OP_INSERT) begin
        res.status <= sts.probe_hit ? STATUS_INSERTED : STATUS_FULL;
      end else begin
        res.status <= sts.probe_hit ? STATUS_FOUND : STATUS_NOT_FOUND;
      end
      res.slot <= sts.probe_hit ? SLOT_W'(prev_pos) : '0;
    end

    if (cmd.out_load) begin
      result <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_write) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  always_comb begin
    ram_we    = cmd.clr_write || (cmd.probe_run && sts.probe_hit && (op == OP_INSERT));
    ram_waddr = cmd.clr_write ? clr_addr : prev_pos;
    ram_wdata = cmd.clr_write ? '0 : val;
  end

  dht_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (pos),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/double_hash_table_top.sv =====
// Top level of the open-addressing hash table with double hashing.
//
//  Channel   Dir  Handshake                  Beat contents
//  item      in   item_valid / item_ready    opcode (insert/search), 31-bit value
//  result    out  result_valid / result_ready status, slot
//  cfg       in   cfg_we (no wait)           cfg_index, cfg_data (table_size, second_prime)
//
// One item at a time. An item passes from acceptance to its result through
// a bit-serial remainder of the value for the home slot and the step prime,
// one setup step, a reduction of the step by the table size, one step to load
// the probe walk, then one store read per probe behind the registered RAM port,
// and one step to load the output register. An item makes at most as many
// probes as the table size (256 slots at most).
// After reset a clearing sweep writes every slot to zero, with item_ready low;
// config writes are taken throughout.
// A finished result sits in its own output register, so the next item is
// accepted while that beat still waits for result_ready.
`default_nettype none

module double_hash_table_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // item channel
  input  wire logic                           item_valid,
  output logic                                item_ready,
  input  wire dht_pkg::in_item_t              item,
  // result channel
  output logic                                result_valid,
  input  wire logic                           result_ready,
  output dht_pkg::out_item_t                  result,
  // config write port
  input  wire logic                           cfg_we,
  input  wire logic [dht_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dht_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dht_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  // Sequence clear, hashing, probing and result hand-off
  dht_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  // Hold config, compute hashes, walk the probe sequence, own the store
  dht_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .result    (result),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire
